@@ design/vmgt_pkg.sv @@
// shared types, constants and field layout for the multicast group table
package vmgt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam int OP_W     = 3;
    localparam int NET_W    = 24;
    localparam int GROUP_W  = 32;
    localparam int RX_W     = 4;
    localparam int STATUS_W = 3;
    localparam int HIT_W    = 4;
    localparam int CNT_W    = 32;
    localparam int ACTIVE_W = 5;

    // input tdata layout
    localparam int IN_NET_LSB   = 0;
    localparam int IN_GROUP_LSB = IN_NET_LSB + NET_W;
    localparam int IN_RX_LSB    = IN_GROUP_LSB + GROUP_W;
    localparam int IN_TDATA_W   = 64;

    // output tdata layout
    localparam int OUT_USED_W  = HIT_W + GROUP_W + NET_W + 6 * CNT_W + ACTIVE_W;
    localparam int OUT_TDATA_W = 264;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    localparam logic [GROUP_W-1:0] GROUP_LOW  = 32'hE000_0000;
    localparam logic [GROUP_W-1:0] GROUP_HIGH = 32'hEFFF_FFFF;
    localparam logic [7:0]         AUTO_OCTET = 8'd239;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_JOIN      = 3'd0,
        OP_AUTO_JOIN = 3'd1,
        OP_LEAVE     = 3'd2,
        OP_LOOKUP    = 3'd3,
        OP_SEND      = 3'd4,
        OP_RECV      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_JOIN,
        K_INVALID,
        K_LEAVE,
        K_LOOKUP,
        K_SEND,
        K_RECV
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [NET_W-1:0]   net_id;
        logic [GROUP_W-1:0] group;
        logic [RX_W-1:0]    rx_slot;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

    typedef enum logic {
        B_IDLE,
        B_EXEC
    } back_state_t;

    typedef struct packed {
        status_t             status;
        logic [HIT_W-1:0]    hit_slot;
        logic [GROUP_W-1:0]  entry_group;
        logic [NET_W-1:0]    entry_net_id;
        logic [CNT_W-1:0]    entry_tx;
        logic [CNT_W-1:0]    entry_rx;
        logic [CNT_W-1:0]    total_tx;
        logic [CNT_W-1:0]    total_rx;
        logic [CNT_W-1:0]    joins_total;
        logic [CNT_W-1:0]    leaves_total;
        logic [ACTIVE_W-1:0] active_groups;
    } result_t;

endpackage

@@ design/vni_multicast_group_table_core.sv @@
// top level of the network id to multicast group table
// Maps 24-bit network ids to IPv4 multicast groups in a 16-slot table with
// per-entry and total packet counters. Items go through a front decoder into
// a two-deep queue; the back part takes one item at a time in two states. In
// idle it pops the item and matches its network id against all slots in
// parallel (a receive checks its rx slot); in execute it writes the table and
// counters back and loads the result register once that register is free, and
// only then pops the next item. The input side keeps taking items while a
// result waits, until the queue fills. There is no clearing pass after reset.
module vni_multicast_group_table_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // net_id[23:0], group_addr[55:24], rx_slot[59:56], zero fill
    input  logic [vmgt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op[2:0]
    input  logic [vmgt_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit_slot[3:0], entry_group[35:4], entry_net_id[59:36], entry_tx[91:60],
    // entry_rx[123:92], total_tx[155:124], total_rx[187:156],
    // joins_total[219:188], leaves_total[251:220], active_groups[256:252], zero fill
    output logic [vmgt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [vmgt_pkg::STATUS_W-1:0]    m_axis_tuser
);

    vmgt_pkg::q_status_t q_status;
    vmgt_pkg::cmd_t      push_cmd;
    vmgt_pkg::cmd_t      head_cmd;
    vmgt_pkg::result_t   res;
    logic                push;
    logic                pop;

    vmgt_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    vmgt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    vmgt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {{vmgt_pkg::OUT_PAD_W{1'b0}},
                           res.active_groups,
                           res.leaves_total,
                           res.joins_total,
                           res.total_rx,
                           res.total_tx,
                           res.entry_rx,
                           res.entry_tx,
                           res.entry_net_id,
                           res.entry_group,
                           res.hit_slot};

endmodule

@@ design/vmgt_front.sv @@
// front part: takes input items, decodes the op and checks the group address
module vmgt_front
(
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [vmgt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [vmgt_pkg::OP_W-1:0]      s_axis_tuser,
    input  vmgt_pkg::q_status_t            q_status,
    output logic                           push,
    output vmgt_pkg::cmd_t                 push_cmd
);

    logic [vmgt_pkg::NET_W-1:0]   net_id;
    logic [vmgt_pkg::GROUP_W-1:0] group_in;
    logic [vmgt_pkg::GROUP_W-1:0] group_sel;
    logic                         class_d;

    assign net_id   = s_axis_tdata[vmgt_pkg::IN_NET_LSB +: vmgt_pkg::NET_W];
    assign group_in = s_axis_tdata[vmgt_pkg::IN_GROUP_LSB +: vmgt_pkg::GROUP_W];

    // auto join builds 239.x.y.z from the network id
    assign group_sel = (vmgt_pkg::op_t'(s_axis_tuser) == vmgt_pkg::OP_AUTO_JOIN)
                     ? {vmgt_pkg::AUTO_OCTET, net_id} : group_in;
    assign class_d   = (group_sel >= vmgt_pkg::GROUP_LOW) && (group_sel <= vmgt_pkg::GROUP_HIGH);

    always_comb
    begin
        push_cmd.net_id  = net_id;
        push_cmd.group   = group_sel;
        push_cmd.rx_slot = s_axis_tdata[vmgt_pkg::IN_RX_LSB +: vmgt_pkg::RX_W];
        case (vmgt_pkg::op_t'(s_axis_tuser))
            vmgt_pkg::OP_JOIN,
            vmgt_pkg::OP_AUTO_JOIN: push_cmd.kind = class_d ? vmgt_pkg::K_JOIN
                                                            : vmgt_pkg::K_INVALID;
            vmgt_pkg::OP_LEAVE:     push_cmd.kind = vmgt_pkg::K_LEAVE;
            vmgt_pkg::OP_LOOKUP:    push_cmd.kind = vmgt_pkg::K_LOOKUP;
            vmgt_pkg::OP_SEND:      push_cmd.kind = vmgt_pkg::K_SEND;
            vmgt_pkg::OP_RECV:      push_cmd.kind = vmgt_pkg::K_RECV;
            default:                push_cmd.kind = vmgt_pkg::K_NOP;
        endcase
    end

    assign s_axis_tready = q_status.not_full;
    assign push          = s_axis_tvalid && q_status.not_full;

endmodule

@@ design/vmgt_queue.sv @@
// short command queue between the front and back parts
module vmgt_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vmgt_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output vmgt_pkg::cmd_t      head_cmd,
    output vmgt_pkg::q_status_t q_status
);

    vmgt_pkg::cmd_t                queue_reg [vmgt_pkg::QUEUE_DEPTH];
    logic [vmgt_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [vmgt_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [vmgt_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [vmgt_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [vmgt_pkg::QCNT_W-1:0]   count_reg;
    logic [vmgt_pkg::QCNT_W-1:0]   count_next;

    localparam logic [vmgt_pkg::QPTR_W-1:0] PTR_LAST = vmgt_pkg::QPTR_W'(vmgt_pkg::QUEUE_DEPTH - 1);
    localparam logic [vmgt_pkg::QCNT_W-1:0] CNT_FULL = vmgt_pkg::QCNT_W'(vmgt_pkg::QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd           = queue_reg[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.not_full  = (count_reg != CNT_FULL);

endmodule

@@ design/vmgt_back.sv @@
// back part: table match, write-back, counters and result register
module vmgt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  vmgt_pkg::cmd_t      head_cmd,
    input  vmgt_pkg::q_status_t q_status,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output vmgt_pkg::result_t   res
);

    localparam int SLOTS = vmgt_pkg::TABLE_SLOTS;
    localparam int SW    = vmgt_pkg::SLOT_W;
    localparam int CW    = vmgt_pkg::CNT_W;

    // table
    logic [SLOTS-1:0]               valid_reg;
    logic [vmgt_pkg::NET_W-1:0]     net_reg  [SLOTS];
    logic [vmgt_pkg::GROUP_W-1:0]   addr_reg [SLOTS];
    logic [CW-1:0]                  tx_reg   [SLOTS];
    logic [CW-1:0]                  rx_reg   [SLOTS];

    // totals
    logic [CW-1:0]                  sum_tx_reg, sum_tx_next;
    logic [CW-1:0]                  sum_rx_reg, sum_rx_next;
    logic [CW-1:0]                  join_tally_reg, join_tally_next;
    logic [CW-1:0]                  leave_tally_reg, leave_tally_next;
    logic [vmgt_pkg::ACTIVE_W-1:0]  valid_tally_reg, valid_tally_next;

    // control
    vmgt_pkg::back_state_t          state_reg, state_next;
    vmgt_pkg::cmd_t                 cmd_reg;
    logic                           found_reg, free_ok_reg;
    logic [SW-1:0]                  hit_reg, free_reg;
    logic                           res_valid_reg;
    vmgt_pkg::result_t              res_reg;

    // match on the queue head
    logic                           found_c, free_ok_c;
    logic [SW-1:0]                  hit_c, free_c;

    // execute
    logic                           fire;
    vmgt_pkg::status_t              status_c;
    logic [SW-1:0]                  slot_c;
    logic                           new_c, leave_c, tx_c, rx_c, hit_ok;
    logic                           join_w, leave_w, tx_w, rx_w;
    vmgt_pkg::result_t              res_c;

    always_comb
    begin
        found_c   = 1'b0;
        hit_c     = '0;
        free_ok_c = 1'b0;
        free_c    = '0;
        // scanning downward leaves the lowest slot in place
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (net_reg[i] == head_cmd.net_id))
            begin
                found_c = 1'b1;
                hit_c   = SW'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok_c = 1'b1;
                free_c    = SW'(i);
            end
        end
        if (head_cmd.kind == vmgt_pkg::K_RECV)
        begin
            found_c = (32'(head_cmd.rx_slot) < 32'(SLOTS)) && valid_reg[SW'(head_cmd.rx_slot)];
            hit_c   = SW'(head_cmd.rx_slot);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            vmgt_pkg::B_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop        = 1'b1;
                    state_next = vmgt_pkg::B_EXEC;
                end
            end
            vmgt_pkg::B_EXEC:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    fire       = 1'b1;
                    state_next = vmgt_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = vmgt_pkg::B_IDLE;
            end
        endcase

        status_c = vmgt_pkg::ST_NOT_FOUND;
        slot_c   = hit_reg;
        new_c    = 1'b0;
        leave_c  = 1'b0;
        tx_c     = 1'b0;
        rx_c     = 1'b0;
        case (cmd_reg.kind)
            vmgt_pkg::K_JOIN:
            begin
                if (found_reg)
                begin
                    status_c = vmgt_pkg::ST_ALREADY;
                end
                else if (free_ok_reg)
                begin
                    status_c = vmgt_pkg::ST_DONE;
                    slot_c   = free_reg;
                    new_c    = 1'b1;
                end
                else
                begin
                    status_c = vmgt_pkg::ST_FULL;
                end
            end
            vmgt_pkg::K_INVALID:
            begin
                status_c = vmgt_pkg::ST_INVALID;
            end
            vmgt_pkg::K_LEAVE:
            begin
                if (found_reg)
                begin
                    status_c = vmgt_pkg::ST_DONE;
                    leave_c  = 1'b1;
                end
            end
            vmgt_pkg::K_LOOKUP:
            begin
                if (found_reg)
                begin
                    status_c = vmgt_pkg::ST_DONE;
                end
            end
            vmgt_pkg::K_SEND:
            begin
                if (found_reg)
                begin
                    status_c = vmgt_pkg::ST_DONE;
                    tx_c     = 1'b1;
                end
            end
            vmgt_pkg::K_RECV:
            begin
                if (found_reg)
                begin
                    status_c = vmgt_pkg::ST_DONE;
                    rx_c     = 1'b1;
                end
            end
            default:
            begin
                status_c = vmgt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    assign join_w  = fire && new_c;
    assign leave_w = fire && leave_c;
    assign tx_w    = fire && tx_c;
    assign rx_w    = fire && rx_c;
    assign hit_ok  = (status_c == vmgt_pkg::ST_DONE) || (status_c == vmgt_pkg::ST_ALREADY);

    assign sum_tx_next      = sum_tx_reg + CW'(tx_w);
    assign sum_rx_next      = sum_rx_reg + CW'(rx_w);
    assign join_tally_next  = join_tally_reg + CW'(join_w);
    assign leave_tally_next = leave_tally_reg + CW'(leave_w);

    always_comb
    begin
        valid_tally_next = valid_tally_reg;
        if (join_w)
        begin
            valid_tally_next = valid_tally_reg + 1'b1;
        end
        else if (leave_w)
        begin
            valid_tally_next = valid_tally_reg - 1'b1;
        end
    end

    // result fields; a new entry shows its fresh contents
    always_comb
    begin
        res_c.status        = status_c;
        res_c.hit_slot      = '0;
        res_c.entry_group   = '0;
        res_c.entry_net_id  = '0;
        res_c.entry_tx      = '0;
        res_c.entry_rx      = '0;
        if (hit_ok)
        begin
            res_c.hit_slot     = vmgt_pkg::HIT_W'(slot_c);
            res_c.entry_group  = new_c ? cmd_reg.group : addr_reg[slot_c];
            res_c.entry_net_id = new_c ? cmd_reg.net_id : net_reg[slot_c];
            res_c.entry_tx     = new_c ? '0 : tx_reg[slot_c] + CW'(tx_c);
            res_c.entry_rx     = new_c ? '0 : rx_reg[slot_c] + CW'(rx_c);
        end
        res_c.total_tx      = sum_tx_next;
        res_c.total_rx      = sum_rx_next;
        res_c.joins_total   = join_tally_next;
        res_c.leaves_total  = leave_tally_next;
        res_c.active_groups = valid_tally_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vmgt_pkg::B_IDLE;
            valid_reg       <= '0;
            sum_tx_reg      <= '0;
            sum_rx_reg      <= '0;
            join_tally_reg  <= '0;
            leave_tally_reg <= '0;
            valid_tally_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sum_tx_reg      <= sum_tx_next;
            sum_rx_reg      <= sum_rx_next;
            join_tally_reg  <= join_tally_next;
            leave_tally_reg <= leave_tally_next;
            valid_tally_reg <= valid_tally_next;
            if (join_w)
            begin
                valid_reg[free_reg] <= 1'b1;
            end
            if (leave_w)
            begin
                valid_reg[hit_reg] <= 1'b0;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg     <= head_cmd;
            found_reg   <= found_c;
            hit_reg     <= hit_c;
            free_ok_reg <= free_ok_c;
            free_reg    <= free_c;
        end
        if (join_w)
        begin
            net_reg[free_reg]  <= cmd_reg.net_id;
            addr_reg[free_reg] <= cmd_reg.group;
            tx_reg[free_reg]   <= '0;
            rx_reg[free_reg]   <= '0;
        end
        if (tx_w)
        begin
            tx_reg[hit_reg] <= tx_reg[hit_reg] + 1'b1;
        end
        if (rx_w)
        begin
            rx_reg[hit_reg] <= rx_reg[hit_reg] + 1'b1;
        end
        if (fire)
        begin
            res_reg <= res_c;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // the active count always tracks the valid bits
    a_tally_matches: assert property (@(posedge clk) disable iff (!rst_n)
        vmgt_pkg::ACTIVE_W'($countones(valid_reg)) == valid_tally_reg)
        else $error("active count out of step with valid bits");

    a_exec_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vmgt_pkg::B_EXEC && (!res_valid_reg || res_ready))
        |=> (res_valid_reg && state_reg == vmgt_pkg::B_IDLE))
        else $error("execute step did not load the result register");

    a_join_counts: assert property (@(posedge clk) disable iff (!rst_n)
        join_w |=> (valid_tally_reg == $past(valid_tally_reg) + 1'b1)
                   && (join_tally_reg == $past(join_tally_reg) + 1'b1))
        else $error("new join not counted");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != vmgt_pkg::ST_DONE
                       && res_reg.status != vmgt_pkg::ST_ALREADY)
        |-> (res_reg.hit_slot == '0 && res_reg.entry_group == '0
             && res_reg.entry_tx == '0 && res_reg.entry_rx == '0))
        else $error("entry fields not cleared on a miss");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the network id to multicast group table core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [vmgt_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [vmgt_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int O_GRP   = vmgt_pkg::HIT_W;
    localparam int O_NET   = O_GRP + vmgt_pkg::GROUP_W;
    localparam int O_TX    = O_NET + vmgt_pkg::NET_W;
    localparam int O_RX    = O_TX + vmgt_pkg::CNT_W;
    localparam int O_TTX   = O_RX + vmgt_pkg::CNT_W;
    localparam int O_TRX   = O_TTX + vmgt_pkg::CNT_W;
    localparam int O_JOIN  = O_TRX + vmgt_pkg::CNT_W;
    localparam int O_LEAVE = O_JOIN + vmgt_pkg::CNT_W;
    localparam int O_ACT   = O_LEAVE + vmgt_pkg::CNT_W;

    localparam int RANDOM_ITEMS   = 430;
    localparam int TAIL_ITEMS     = 60;
    localparam int LONG_HOLD      = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 24;

    // tracks the table contents and compares replies in order
    class group_table_scoreboard;
        bit                                live[vmgt_pkg::TABLE_SLOTS];
        logic [vmgt_pkg::NET_W-1:0]        ids[vmgt_pkg::TABLE_SLOTS];
        logic [vmgt_pkg::GROUP_W-1:0]      groups[vmgt_pkg::TABLE_SLOTS];
        logic [vmgt_pkg::CNT_W-1:0]        tx[vmgt_pkg::TABLE_SLOTS];
        logic [vmgt_pkg::CNT_W-1:0]        rx[vmgt_pkg::TABLE_SLOTS];
        logic [vmgt_pkg::CNT_W-1:0]        sent_total;
        logic [vmgt_pkg::CNT_W-1:0]        recv_total;
        logic [vmgt_pkg::CNT_W-1:0]        joins;
        logic [vmgt_pkg::CNT_W-1:0]        leaves;
        logic [vmgt_pkg::ACTIVE_W-1:0]     active;
        vmgt_pkg::result_t                 expected_replies[$];
        int                                errors;

        function new();
            for (int i = 0; i < vmgt_pkg::TABLE_SLOTS; i++)
            begin
                live[i] = 0;
                ids[i] = '0;
                groups[i] = '0;
                tx[i] = '0;
                rx[i] = '0;
            end
            sent_total = '0;
            recv_total = '0;
            joins = '0;
            leaves = '0;
            active = '0;
            errors = 0;
        endfunction

        function int match_slot(logic [vmgt_pkg::NET_W-1:0] id);
            for (int i = 0; i < vmgt_pkg::TABLE_SLOTS; i++)
                if (live[i] && ids[i] == id)
                    return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < vmgt_pkg::TABLE_SLOTS; i++)
                if (!live[i])
                    return i;
            return -1;
        endfunction

        function vmgt_pkg::result_t apply_request(logic [vmgt_pkg::OP_W-1:0] op,
                                                  logic [vmgt_pkg::NET_W-1:0] id,
                                                  logic [vmgt_pkg::GROUP_W-1:0] grp,
                                                  logic [vmgt_pkg::RX_W-1:0] rxs);
            vmgt_pkg::result_t            r;
            int                           slot;
            logic [vmgt_pkg::GROUP_W-1:0] g;
            r = '0;
            r.status = vmgt_pkg::ST_NOT_FOUND;
            slot = -1;
            g = grp;
            if (op == vmgt_pkg::OP_AUTO_JOIN)
                g = {vmgt_pkg::AUTO_OCTET, id};
            if (op == vmgt_pkg::OP_JOIN || op == vmgt_pkg::OP_AUTO_JOIN)
            begin
                if (g < vmgt_pkg::GROUP_LOW || g > vmgt_pkg::GROUP_HIGH)
                begin
                    r.status = vmgt_pkg::ST_INVALID;
                end
                else
                begin
                    slot = match_slot(id);
                    if (slot >= 0)
                    begin
                        r.status = vmgt_pkg::ST_ALREADY;
                    end
                    else
                    begin
                        slot = free_slot();
                        if (slot < 0)
                        begin
                            r.status = vmgt_pkg::ST_FULL;
                        end
                        else
                        begin
                            live[slot] = 1;
                            ids[slot] = id;
                            groups[slot] = g;
                            tx[slot] = '0;
                            rx[slot] = '0;
                            joins++;
                            active++;
                            r.status = vmgt_pkg::ST_DONE;
                        end
                    end
                end
            end
            else if (op == vmgt_pkg::OP_LEAVE)
            begin
                slot = match_slot(id);
                if (slot >= 0)
                begin
                    // reply still shows the entry as it was
                    live[slot] = 0;
                    leaves++;
                    active--;
                    r.status = vmgt_pkg::ST_DONE;
                end
            end
            else if (op == vmgt_pkg::OP_LOOKUP)
            begin
                slot = match_slot(id);
                if (slot >= 0)
                    r.status = vmgt_pkg::ST_DONE;
            end
            else if (op == vmgt_pkg::OP_SEND)
            begin
                slot = match_slot(id);
                if (slot >= 0)
                begin
                    tx[slot]++;
                    sent_total++;
                    r.status = vmgt_pkg::ST_DONE;
                end
            end
            else if (op == vmgt_pkg::OP_RECV)
            begin
                if (live[rxs])
                begin
                    slot = rxs;
                    rx[slot]++;
                    recv_total++;
                    r.status = vmgt_pkg::ST_DONE;
                end
            end
            if (r.status == vmgt_pkg::ST_DONE || r.status == vmgt_pkg::ST_ALREADY)
            begin
                r.hit_slot = slot[vmgt_pkg::HIT_W-1:0];
                r.entry_group = groups[slot];
                r.entry_net_id = ids[slot];
                r.entry_tx = tx[slot];
                r.entry_rx = rx[slot];
            end
            r.total_tx = sent_total;
            r.total_rx = recv_total;
            r.joins_total = joins;
            r.leaves_total = leaves;
            r.active_groups = active;
            return r;
        endfunction

        function void note_request(logic [vmgt_pkg::OP_W-1:0] op,
                                   logic [vmgt_pkg::NET_W-1:0] id,
                                   logic [vmgt_pkg::GROUP_W-1:0] grp,
                                   logic [vmgt_pkg::RX_W-1:0] rxs);
            expected_replies.push_back(apply_request(op, id, grp, rxs));
        endfunction

        function void check_field(string label, logic [vmgt_pkg::CNT_W-1:0] want,
                                  logic [vmgt_pkg::CNT_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [vmgt_pkg::STATUS_W-1:0] user,
                                  logic [vmgt_pkg::OUT_TDATA_W-1:0] d);
            vmgt_pkg::result_t want;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual status %0h data %0h",
                         $time, user, d);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            check_field("status", 32'(want.status), 32'(user));
            check_field("hit_slot", 32'(want.hit_slot), 32'(d[0 +: vmgt_pkg::HIT_W]));
            check_field("entry_group", want.entry_group, d[O_GRP +: vmgt_pkg::GROUP_W]);
            check_field("entry_net_id", 32'(want.entry_net_id),
                        32'(d[O_NET +: vmgt_pkg::NET_W]));
            check_field("entry_tx", want.entry_tx, d[O_TX +: vmgt_pkg::CNT_W]);
            check_field("entry_rx", want.entry_rx, d[O_RX +: vmgt_pkg::CNT_W]);
            check_field("total_tx", want.total_tx, d[O_TTX +: vmgt_pkg::CNT_W]);
            check_field("total_rx", want.total_rx, d[O_TRX +: vmgt_pkg::CNT_W]);
            check_field("joins_total", want.joins_total, d[O_JOIN +: vmgt_pkg::CNT_W]);
            check_field("leaves_total", want.leaves_total, d[O_LEAVE +: vmgt_pkg::CNT_W]);
            check_field("active_groups", 32'(want.active_groups),
                        32'(d[O_ACT +: vmgt_pkg::ACTIVE_W]));
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [vmgt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [vmgt_pkg::OP_W-1:0]        s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [vmgt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [vmgt_pkg::STATUS_W-1:0]    m_axis_tuser;

    group_table_scoreboard            sb;
    int                               sent_count;
    int                               total_items;
    int                               idle_cycles;
    logic [vmgt_pkg::NET_W-1:0]       net_pool[POOL_SIZE];

    vni_multicast_group_table_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // no idling in the tail, and every third stretch of 64 items runs flat out
    function automatic bit idling_allowed();
        return sent_count < total_items - TAIL_ITEMS && (sent_count / 64) % 3 != 2;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_request(logic [vmgt_pkg::OP_W-1:0] op,
                                logic [vmgt_pkg::NET_W-1:0] id,
                                logic [vmgt_pkg::GROUP_W-1:0] grp,
                                logic [vmgt_pkg::RX_W-1:0] rxs);
        logic [vmgt_pkg::IN_TDATA_W-1:0] data;
        if (idling_allowed() && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        data = '0;
        data[vmgt_pkg::IN_NET_LSB +: vmgt_pkg::NET_W] = id;
        data[vmgt_pkg::IN_GROUP_LSB +: vmgt_pkg::GROUP_W] = grp;
        data[vmgt_pkg::IN_RX_LSB +: vmgt_pkg::RX_W] = rxs;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, id, grp, rxs);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic logic [vmgt_pkg::NET_W-1:0] pick_net();
        if ($urandom_range(0, 3) == 0)
            return vmgt_pkg::NET_W'($urandom);
        return net_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // phase 0 fills the table, phase 1 is mixed, phase 2 drains it
    function automatic logic [vmgt_pkg::OP_W-1:0] pick_op(int phase);
        int unsigned cut[3][7] = '{
            '{45, 60, 70, 80, 90, 97, 100},
            '{25, 35, 50, 65, 82, 97, 100},
            '{15, 20, 55, 70, 85, 97, 100}
        };
        logic [vmgt_pkg::OP_W-1:0] order[7] = '{vmgt_pkg::OP_JOIN, vmgt_pkg::OP_AUTO_JOIN,
                                                vmgt_pkg::OP_LEAVE, vmgt_pkg::OP_LOOKUP,
                                                vmgt_pkg::OP_SEND, vmgt_pkg::OP_RECV,
                                                OP_SPARE_A};
        int unsigned roll;
        roll = $urandom_range(0, 99);
        for (int k = 0; k < 7; k++)
        begin
            if (roll < cut[phase][k])
            begin
                if (order[k] == OP_SPARE_A && $urandom_range(0, 1) == 1)
                    return OP_SPARE_B;
                return order[k];
            end
        end
        return vmgt_pkg::OP_LOOKUP;
    endfunction

    task automatic run_directed();
        push_request(OP_SPARE_A, 24'h000000, 32'hE000_0000, 4'h0);
        push_request(OP_SPARE_B, 24'hFFFFFF, 32'hFFFF_FFFF, 4'hF);
        push_request(vmgt_pkg::OP_LOOKUP, 24'h000000, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_RECV, 24'h000000, 32'h0000_0000, 4'h0);
        // class d bounds from both sides
        push_request(vmgt_pkg::OP_JOIN, 24'h000000, 32'hDFFF_FFFF, 4'h0);
        push_request(vmgt_pkg::OP_JOIN, 24'h000000, 32'hF000_0000, 4'h0);
        push_request(vmgt_pkg::OP_JOIN, 24'h000000, 32'hE000_0000, 4'h0);
        push_request(vmgt_pkg::OP_JOIN, 24'hFFFFFF, 32'hEFFF_FFFF, 4'hF);
        push_request(vmgt_pkg::OP_JOIN, 24'h000000, 32'hE123_4567, 4'h0);
        push_request(vmgt_pkg::OP_AUTO_JOIN, 24'h123456, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_AUTO_JOIN, 24'hFFFFFF, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_AUTO_JOIN, 24'h000000, 32'hFFFF_FFFF, 4'h0);
        push_request(vmgt_pkg::OP_SEND, 24'hFFFFFF, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_SEND, 24'h555555, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_RECV, 24'h000000, 32'h0000_0000, 4'h1);
        push_request(vmgt_pkg::OP_RECV, 24'h000000, 32'h0000_0000, 4'hF);
        push_request(vmgt_pkg::OP_LOOKUP, 24'hFFFFFF, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_RECV, 24'h000000, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_LEAVE, 24'h000000, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_LEAVE, 24'h000000, 32'h0000_0000, 4'h0);
        // freed slot zero is reused with counters cleared
        push_request(vmgt_pkg::OP_JOIN, 24'hABCDEF, 32'hE000_0001, 4'h0);
        push_request(vmgt_pkg::OP_RECV, 24'h000000, 32'h0000_0000, 4'h0);
        push_request(vmgt_pkg::OP_SEND, 24'hABCDEF, 32'h0000_0000, 4'h0);
    endtask

    task automatic run_random();
        logic [vmgt_pkg::OP_W-1:0]    op;
        logic [vmgt_pkg::GROUP_W-1:0] grp;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op = pick_op((i / 60) % 3);
            if ($urandom_range(0, 6) == 0)
                grp = $urandom;
            else
                grp = {4'hE, 28'($urandom)};
            push_request(op, pick_net(), grp, vmgt_pkg::RX_W'($urandom));
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        int  stall_left;
        bit  long_hold_done;
        stall_left = 0;
        long_hold_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && sent_count >= 60)
            begin
                stall_left = LONG_HOLD;
                long_hold_done = 1;
            end
            else if (stall_left == 0 && idling_allowed() && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sent_count = 0;
        total_items = RANDOM_ITEMS + 23;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        net_pool[0] = 24'h000000;
        net_pool[1] = 24'hFFFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            net_pool[i] = vmgt_pkg::NET_W'($urandom);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
design/vmgt_pkg.sv
design/vmgt_front.sv
design/vmgt_queue.sv
design/vmgt_back.sv
design/vni_multicast_group_table_core.sv
verif/testbench.sv
